@@ hw/rtl/pcrv_pkg.sv @@
// Package for the point cloud relative volume block.
// Holds controller states, command/status structs and fixed constants.
// No dependencies.
package pcrv_pkg;

  localparam int unsigned OUT_W     = 32;
  localparam int unsigned RATIO_W   = 17;
  localparam int unsigned OCC_OUT_W = 13;
  localparam int unsigned CS_W      = 16;
  localparam int unsigned MCP_W     = 10;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic [RATIO_W-1:0] RATIO_SAT = 17'h1FFFF;
  localparam logic [CS_W-1:0]    CS_RESET  = 16'd100;
  localparam logic [MCP_W-1:0]   MCP_RESET = 10'd2;

  localparam logic REG_CELL_SIZE = 1'b0;
  localparam logic REG_MIN_CELL  = 1'b1;

  typedef enum logic [19:0] {
    ST_LOAD    = 20'h00001,
    ST_CHECK   = 20'h00002,
    ST_DECIDE  = 20'h00004,
    ST_SIDE    = 20'h00008,
    ST_CLEAR   = 20'h00010,
    ST_PT_RD   = 20'h00020,
    ST_PT_MUL  = 20'h00040,
    ST_IDX     = 20'h00080,
    ST_IDX_W   = 20'h00100,
    ST_CELL_RD = 20'h00200,
    ST_CELL_WR = 20'h00400,
    ST_SW_RD   = 20'h00800,
    ST_SW_ACC  = 20'h01000,
    ST_DEN1    = 20'h02000,
    ST_DEN2    = 20'h04000,
    ST_RPREP   = 20'h08000,
    ST_RSTART  = 20'h10000,
    ST_RWAIT   = 20'h20000,
    ST_EMIT    = 20'h40000
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic side_start;
    logic side_take;
    logic clr_wr;
    logic pt_rd;
    logic pt_mul;
    logic idx_start;
    logic cell_rd;
    logic cell_wr;
    logic sw_rd;
    logic sw_acc;
    logic den1;
    logic den2;
    logic rprep;
    logic rstart;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic sat;
    logic div_done;
    logic clr_last;
    logic pt_last;
    logic sw_last;
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/pcrv_div.sv @@
// Restoring divider, one quotient bit per cycle, caller-supplied start remainder.
// Used for grid sides, cell indexes and the final ratio. No package use.
module pcrv_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned LW = 20,
  parameter int unsigned CW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem0,
  input  logic [LW-1:0] low,
  input  logic [DW-1:0] den,
  input  logic [CW-1:0] iters,
  output logic          done,
  output logic [LW-1:0] quo
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] low_r, low_nxt;
  logic [LW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   remx;
  logic          qbit;

  assign remx = {rem_r, low_r[LW-1]};
  assign qbit = remx >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iters;
      rem_nxt  = rem0;
      low_nxt  = low;
      quo_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = qbit ? DW'(remx - {1'b0, den_r}) : remx[DW-1:0];
      low_nxt = {low_r[LW-2:0], 1'b0};
      quo_nxt = {quo_r[LW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ hw/rtl/pcrv_ctrl.sv @@
// Controller state machine for the relative volume block.
// Depends on pcrv_pkg; drives pcrv_dp through cmd_t, reads status_t.
module pcrv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output pcrv_pkg::cmd_t    cmd,
  input  pcrv_pkg::status_t st
);

  pcrv_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      pcrv_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid && in_tlast) state_nxt = pcrv_pkg::ST_CHECK;
      end
      pcrv_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = pcrv_pkg::ST_DECIDE;
      end
      pcrv_pkg::ST_DECIDE: begin
        if (st.degen) begin
          state_nxt = pcrv_pkg::ST_EMIT;
        end else begin
          cmd.side_start = 1'b1;
          state_nxt      = pcrv_pkg::ST_SIDE;
        end
      end
      pcrv_pkg::ST_SIDE: begin
        if (st.div_done) begin
          cmd.side_take = 1'b1;
          state_nxt     = pcrv_pkg::ST_CLEAR;
        end
      end
      pcrv_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = pcrv_pkg::ST_PT_RD;
      end
      pcrv_pkg::ST_PT_RD: begin
        cmd.pt_rd = 1'b1;
        state_nxt = pcrv_pkg::ST_PT_MUL;
      end
      pcrv_pkg::ST_PT_MUL: begin
        cmd.pt_mul = 1'b1;
        state_nxt  = pcrv_pkg::ST_IDX;
      end
      pcrv_pkg::ST_IDX: begin
        cmd.idx_start = 1'b1;
        state_nxt     = pcrv_pkg::ST_IDX_W;
      end
      pcrv_pkg::ST_IDX_W: begin
        if (st.div_done) state_nxt = pcrv_pkg::ST_CELL_RD;
      end
      pcrv_pkg::ST_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = pcrv_pkg::ST_CELL_WR;
      end
      pcrv_pkg::ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_nxt   = st.pt_last ? pcrv_pkg::ST_SW_RD : pcrv_pkg::ST_PT_RD;
      end
      pcrv_pkg::ST_SW_RD: begin
        cmd.sw_rd = 1'b1;
        state_nxt = pcrv_pkg::ST_SW_ACC;
      end
      pcrv_pkg::ST_SW_ACC: begin
        cmd.sw_acc = 1'b1;
        state_nxt  = st.sw_last ? pcrv_pkg::ST_DEN1 : pcrv_pkg::ST_SW_RD;
      end
      pcrv_pkg::ST_DEN1: begin
        cmd.den1  = 1'b1;
        state_nxt = pcrv_pkg::ST_DEN2;
      end
      pcrv_pkg::ST_DEN2: begin
        cmd.den2  = 1'b1;
        state_nxt = pcrv_pkg::ST_RPREP;
      end
      pcrv_pkg::ST_RPREP: begin
        cmd.rprep = 1'b1;
        state_nxt = pcrv_pkg::ST_RSTART;
      end
      pcrv_pkg::ST_RSTART: begin
        if (st.sat) begin
          state_nxt = pcrv_pkg::ST_EMIT;
        end else begin
          cmd.rstart = 1'b1;
          state_nxt  = pcrv_pkg::ST_RWAIT;
        end
      end
      pcrv_pkg::ST_RWAIT: begin
        if (st.div_done) state_nxt = pcrv_pkg::ST_EMIT;
      end
      pcrv_pkg::ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = pcrv_pkg::ST_LOAD;
        end
      end
      default: state_nxt = pcrv_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcrv_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/pcrv_dp.sv @@
// Datapath: point store, bounding box, cell grid memory, sums and result register.
// Depends on pcrv_pkg and pcrv_div; commanded by pcrv_ctrl.
module pcrv_dp #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned GRID_SIDE  = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcrv_pkg::cmd_t             cmd,
  output pcrv_pkg::status_t          st,
  input  logic [COORD_BITS-1:0]      x_coord,
  input  logic [COORD_BITS-1:0]      y_coord,
  input  logic [COORD_BITS-1:0]      z_coord,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pcrv_pkg::CS_W-1:0]  cfg_wdata,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [pcrv_pkg::OUT_W-1:0] out_tdata
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned GB     = $clog2(GRID_SIDE + 1);
  localparam int unsigned IW     = $clog2(GRID_SIDE);
  localparam int unsigned CA_W   = 2 * IW;
  localparam int unsigned CELLS  = 1 << CA_W;
  localparam int unsigned PK_W   = CB - 1;
  localparam int unsigned OCC_W  = CA_W + 1;
  localparam int unsigned DW     = CB + 2 * GB + 2;
  localparam int unsigned LW     = (CB > pcrv_pkg::FRAC_BITS) ? CB : pcrv_pkg::FRAC_BITS;
  localparam int unsigned CW     = $clog2(LW + 1);
  localparam int unsigned PW     = CB + GB;
  localparam int unsigned CMP_W  = CNT_W + pcrv_pkg::MCP_W;

  localparam logic signed [CB-1:0] COORD_TOP = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] COORD_BOT = {1'b1, {(CB-1){1'b0}}};

  // configuration
  logic [pcrv_pkg::CS_W-1:0]  cs_r;
  logic [pcrv_pkg::MCP_W-1:0] mcp_r;
  logic [pcrv_pkg::CS_W-1:0]  cs_eff;

  // cluster
  logic [CNT_W-1:0]     cnt_r;
  logic                 ovf_r;
  logic signed [CB-1:0] minx_r, miny_r, minz_r, maxx_r, maxy_r, maxz_r;
  logic                 full;
  logic [3*CB-1:0]      pt_mem [0:MAX_POINTS-1];
  logic [3*CB-1:0]      pt_q_r;

  // evaluation
  logic                 degen_r;
  logic [CB-1:0]        ex_r, ey_r, ez_r;
  logic signed [CB:0]   dex, dey, dez;
  logic [GB-1:0]        nx_r, ny_r;
  logic [CA_W-1:0]      clr_r;
  logic [CNT_W-1:0]     ptr_r;
  logic [PW-1:0]        ax_r, ay_r;
  logic signed [CB-1:0] z_r;
  logic signed [CB:0]   dpx, dpy;
  logic [CA_W-1:0]      caddr_r, caddr_nxt, rd_addr;
  logic [CNT_W-1:0]     cnt_mem [0:CELLS-1];
  logic [PK_W-1:0]      pk_mem  [0:CELLS-1];
  logic [CNT_W-1:0]     cc_q_r;
  logic [PK_W-1:0]      pk_q_r;
  logic [PK_W-1:0]      zpos;
  logic [IW-1:0]        si_r, sj_r;
  logic [DW-1:0]        sum_r;
  logic [OCC_W-1:0]     occ_r;
  logic [2*GB-1:0]      nn_r;
  logic [DW-1:0]        den_r;
  logic                 sat_r, q0_r;
  logic [DW-1:0]        r_r;

  // dividers
  logic          dx_start, dy_start, dx_done, dy_done;
  logic [DW-1:0] dx_rem0, dy_rem0, dx_den, dy_den;
  logic [LW-1:0] dx_low, dy_low, dx_quo, dy_quo;
  logic [CW-1:0] d_iters;
  logic [GB-1:0] qx, qy, ixc, iyc, nx_side, ny_side;

  // output
  logic                       out_valid_r;
  logic [pcrv_pkg::OUT_W-1:0] out_data_r;
  logic [pcrv_pkg::RATIO_W-1:0] res;

  assign cs_eff = (cs_r == '0) ? pcrv_pkg::CS_W'(1) : cs_r;
  assign full   = cnt_r == CNT_W'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= pcrv_pkg::CS_RESET;
      mcp_r <= pcrv_pkg::MCP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pcrv_pkg::REG_CELL_SIZE) cs_r <= cfg_wdata;
      else mcp_r <= cfg_wdata[pcrv_pkg::MCP_W-1:0];
    end
  end

  // point load and bounding box
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      minx_r <= COORD_TOP;
      miny_r <= COORD_TOP;
      minz_r <= COORD_TOP;
      maxx_r <= COORD_BOT;
      maxy_r <= COORD_BOT;
      maxz_r <= COORD_BOT;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if ($signed(x_coord) < minx_r) minx_r <= $signed(x_coord);
        if ($signed(y_coord) < miny_r) miny_r <= $signed(y_coord);
        if ($signed(z_coord) < minz_r) minz_r <= $signed(z_coord);
        if ($signed(x_coord) > maxx_r) maxx_r <= $signed(x_coord);
        if ($signed(y_coord) > maxy_r) maxy_r <= $signed(y_coord);
        if ($signed(z_coord) > maxz_r) maxz_r <= $signed(z_coord);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) pt_mem[cnt_r[AW-1:0]] <= {z_coord, y_coord, x_coord};
    if (cmd.pt_rd) pt_q_r <= pt_mem[ptr_r[AW-1:0]];
  end

  // extents
  assign dex = {maxx_r[CB-1], maxx_r} - {minx_r[CB-1], minx_r};
  assign dey = {maxy_r[CB-1], maxy_r} - {miny_r[CB-1], miny_r};
  assign dez = {maxz_r[CB-1], maxz_r} - {minz_r[CB-1], minz_r};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      ex_r    <= dex[CB-1:0];
      ey_r    <= dey[CB-1:0];
      ez_r    <= dez[CB-1:0];
      degen_r <= (cnt_r == '0) || (dex[CB-1:0] == '0) || (dey[CB-1:0] == '0) ||
                 (dez[CB-1:0] == '0);
    end
  end

  // divider operand selection
  assign d_iters = cmd.side_start ? CW'(CB) : (cmd.idx_start ? CW'(GB) :
                   CW'(pcrv_pkg::FRAC_BITS));
  assign dx_start = cmd.side_start || cmd.idx_start || cmd.rstart;
  assign dy_start = cmd.side_start || cmd.idx_start;

  always_comb begin
    if (cmd.side_start) begin
      dx_rem0 = '0;
      dx_low  = LW'(ex_r) << (LW - CB);
      dx_den  = DW'(cs_eff);
    end else if (cmd.idx_start) begin
      dx_rem0 = DW'(ax_r >> GB);
      dx_low  = LW'(ax_r[GB-1:0]) << (LW - GB);
      dx_den  = DW'(ex_r);
    end else begin
      dx_rem0 = r_r;
      dx_low  = '0;
      dx_den  = den_r;
    end
    if (cmd.side_start) begin
      dy_rem0 = '0;
      dy_low  = LW'(ey_r) << (LW - CB);
      dy_den  = DW'(cs_eff);
    end else begin
      dy_rem0 = DW'(ay_r >> GB);
      dy_low  = LW'(ay_r[GB-1:0]) << (LW - GB);
      dy_den  = DW'(ey_r);
    end
  end

  pcrv_div #(.DW(DW), .LW(LW), .CW(CW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(dx_start), .rem0(dx_rem0), .low(dx_low),
    .den(dx_den), .iters(d_iters), .done(dx_done), .quo(dx_quo)
  );

  pcrv_div #(.DW(DW), .LW(LW), .CW(CW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(dy_start), .rem0(dy_rem0), .low(dy_low),
    .den(dy_den), .iters(d_iters), .done(dy_done), .quo(dy_quo)
  );

  // grid sides, clamped to 1..GRID_SIDE
  assign nx_side = (dx_quo == '0) ? GB'(1) :
                   ((dx_quo > LW'(GRID_SIDE)) ? GB'(GRID_SIDE) : dx_quo[GB-1:0]);
  assign ny_side = (dy_quo == '0) ? GB'(1) :
                   ((dy_quo > LW'(GRID_SIDE)) ? GB'(GRID_SIDE) : dy_quo[GB-1:0]);

  // cell index, top edge clamped to last cell
  assign qx  = dx_quo[GB-1:0];
  assign qy  = dy_quo[GB-1:0];
  assign ixc = (qx >= nx_r) ? nx_r - 1'b1 : qx;
  assign iyc = (qy >= ny_r) ? ny_r - 1'b1 : qy;
  assign caddr_nxt = {ixc[IW-1:0], iyc[IW-1:0]};
  assign rd_addr   = cmd.cell_rd ? caddr_nxt : {si_r, sj_r};

  assign dpx  = {pt_q_r[CB-1], pt_q_r[CB-1:0]} - {minx_r[CB-1], minx_r};
  assign dpy  = {pt_q_r[2*CB-1], pt_q_r[2*CB-1:CB]} - {miny_r[CB-1], miny_r};
  assign zpos = z_r[CB-1] ? '0 : z_r[CB-2:0];

  always_ff @(posedge clk) begin
    if (cmd.side_take) begin
      nx_r <= nx_side;
      ny_r <= ny_side;
    end
    if (cmd.pt_mul) begin
      ax_r <= PW'(dpx[CB-1:0]) * PW'(nx_r);
      ay_r <= PW'(dpy[CB-1:0]) * PW'(ny_r);
      z_r  <= pt_q_r[3*CB-1:2*CB];
    end
    if (cmd.cell_rd) caddr_r <= caddr_nxt;
  end

  // loop counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      ptr_r <= '0;
      si_r  <= '0;
      sj_r  <= '0;
      sum_r <= '0;
      occ_r <= '0;
    end else if (cmd.side_take) begin
      clr_r <= '0;
      ptr_r <= '0;
      si_r  <= '0;
      sj_r  <= '0;
      sum_r <= '0;
      occ_r <= '0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.cell_wr) ptr_r <= ptr_r + 1'b1;
      if (cmd.sw_acc) begin
        if (CMP_W'(cc_q_r) > CMP_W'(mcp_r)) begin
          occ_r <= occ_r + 1'b1;
          sum_r <= sum_r + DW'({pk_q_r, 1'b0}) + DW'(ez_r);
        end
        if (GB'(sj_r) == ny_r - 1'b1) begin
          sj_r <= '0;
          si_r <= si_r + 1'b1;
        end else begin
          sj_r <= sj_r + 1'b1;
        end
      end
    end
  end

  // cell grid memory
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cnt_mem[clr_r] <= '0;
      pk_mem[clr_r]  <= '0;
    end else if (cmd.cell_wr) begin
      cnt_mem[caddr_r] <= cc_q_r + 1'b1;
      pk_mem[caddr_r]  <= (zpos > pk_q_r) ? zpos : pk_q_r;
    end
    if (cmd.cell_rd || cmd.sw_rd) begin
      cc_q_r <= cnt_mem[rd_addr];
      pk_q_r <= pk_mem[rd_addr];
    end
  end

  // ratio
  always_ff @(posedge clk) begin
    if (cmd.den1) nn_r <= (2*GB)'(nx_r) * (2*GB)'(ny_r);
    if (cmd.den2) den_r <= DW'(DW'(nn_r) * DW'(ez_r)) << 1;
    if (cmd.rprep) begin
      sat_r <= {1'b0, sum_r} >= {den_r, 1'b0};
      q0_r  <= sum_r >= den_r;
      r_r   <= (sum_r >= den_r) ? sum_r - den_r : sum_r;
    end
  end

  assign res = degen_r ? '0 : (sat_r ? pcrv_pkg::RATIO_SAT :
               {q0_r, dx_quo[pcrv_pkg::FRAC_BITS-1:0]});

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= {ovf_r, degen_r,
                     degen_r ? pcrv_pkg::OCC_OUT_W'(0) : pcrv_pkg::OCC_OUT_W'(occ_r), res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign st.degen    = degen_r;
  assign st.sat      = sat_r;
  assign st.div_done = dx_done;
  assign st.clr_last = clr_r == '1;
  assign st.pt_last  = (ptr_r + 1'b1) == cnt_r;
  assign st.sw_last  = (GB'(si_r) == nx_r - 1'b1) && (GB'(sj_r) == ny_r - 1'b1);
  assign st.out_busy = out_valid_r && !out_tready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("result overwritten before transfer");

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cell_wr |-> (ptr_r < cnt_r))
    else $error("binning past stored points");

  a_no_div_on_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rstart |-> !sat_r)
    else $error("ratio division started on saturated sum");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    dy_start |=> !dy_done)
    else $error("divider done right after start");

endmodule

@@ hw/rtl/point_cloud_relative_volume.sv @@
// Top level of the point cloud relative volume block.
// Depends on pcrv_pkg, pcrv_ctrl, pcrv_dp (and pcrv_div below it).
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tdata x,y,z; tlast last_point
//  out     | out | out_tvalid/tready  | tdata volume,occupied,degenerate,truncated
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//
// Points transfer at one per cycle while loading. After the last point the block
// checks the extents, divides for the grid sides, clears the cell memory, bins
// each stored point by index division, sums over every grid cell and divides
// for the ratio, then emits the result; a degenerate cluster skips to the result,
// and a saturated sum skips the ratio division. Reset is synchronous; no input is
// taken during evaluation; a stalled result holds the next one.
module point_cloud_relative_volume #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned GRID_SIDE  = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // x_coord, y_coord, z_coord from bit 0 up, zero padded
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // relative_volume[16:0], occupied_cells[29:17], degenerate[30], truncated[31]
  output logic [pcrv_pkg::OUT_W-1:0]            out_tdata,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [pcrv_pkg::CS_W-1:0]             cfg_wdata
);

  pcrv_pkg::cmd_t    cmd;
  pcrv_pkg::status_t st;

  pcrv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tlast(in_tlast),
    .in_tready(in_tready), .cmd(cmd), .st(st)
  );

  pcrv_dp #(
    .MAX_POINTS(MAX_POINTS), .GRID_SIDE(GRID_SIDE), .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .x_coord(in_tdata[COORD_BITS-1:0]),
    .y_coord(in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .z_coord(in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata)
  );

endmodule
